[hw/rtl/rgt_pkg.sv]
// Shared types and constants for the ranked gain trial table.
// Used by rgt_cell and ranked_gain_trial_table; depends on nothing.
package rgt_pkg;

    // Width of cell positions and limits carried to the cells (covers depth 64).
    localparam int POS_W = 7;

    localparam logic [15:0] RESET_MIN_HOLD = 16'd20;

    // Cell operations.
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_SHL  = 2'd1;
    localparam logic [1:0] OP_INS  = 2'd2;

    // Record outcomes.
    localparam logic [1:0] OUT_NONE     = 2'd0;
    localparam logic [1:0] OUT_ADDED    = 2'd1;
    localparam logic [1:0] OUT_IMPROVED = 2'd2;
    localparam logic [1:0] OUT_KEPT     = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_HOLD = 3'd0;
    localparam logic [2:0] CFG_POS_P    = 3'd1;
    localparam logic [2:0] CFG_POS_I    = 3'd2;
    localparam logic [2:0] CFG_POS_D    = 3'd3;
    localparam logic [2:0] CFG_NEG_P    = 3'd4;
    localparam logic [2:0] CFG_NEG_I    = 3'd5;
    localparam logic [2:0] CFG_NEG_D    = 3'd6;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] p;
        logic [15:0] i;
        logic [15:0] d;
        logic [15:0] t;
    } t_rec;

    typedef struct packed {
        logic        which_list;
        logic [15:0] held_seconds;
        logic [9:0]  fresh_p;
        logic [9:0]  fresh_i;
        logic [13:0] fresh_d;
    } t_in;

    typedef struct packed {
        logic [15:0] next_id;
        logic [15:0] next_p;
        logic [15:0] next_i;
        logic [15:0] next_d;
        logic        reused_from_table;
        logic [1:0]  record_outcome;
        logic [3:0]  stored_count;
    } t_out;

    typedef struct packed {
        logic [1:0]       op;
        logic             list;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lim;
        t_rec             new_rec;
    } t_cell_ctl;

endpackage

[hw/rtl/rgt_cell.sv]
// One table slot for both lists; shifts with its neighbors on command.
// Depends on rgt_pkg.
module rgt_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  rgt_pkg::t_cell_ctl i_ctl,
    input  rgt_pkg::t_rec      i_left,
    input  rgt_pkg::t_rec      i_right,
    output rgt_pkg::t_rec      o_rec,
    output logic               o_id_eq,
    output logic               o_t_gt
);
    localparam logic [rgt_pkg::POS_W-1:0] MY_POS = rgt_pkg::POS_W'(IDX);
    localparam logic [rgt_pkg::POS_W-1:0] NX_POS = rgt_pkg::POS_W'(IDX + 1);

    rgt_pkg::t_rec r_rec [2];

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            rgt_pkg::OP_SHL: begin
                if (MY_POS >= i_ctl.pos && NX_POS < i_ctl.lim) begin
                    r_rec[i_ctl.list] <= i_right;
                end
            end
            rgt_pkg::OP_INS: begin
                if (MY_POS == i_ctl.pos) begin
                    r_rec[i_ctl.list] <= i_ctl.new_rec;
                end else if (MY_POS > i_ctl.pos && MY_POS <= i_ctl.lim) begin
                    r_rec[i_ctl.list] <= i_left;
                end
            end
            default: begin
            end
        endcase
    end

    // Compare against the record being reported.
    assign o_rec   = r_rec[i_ctl.list];
    assign o_id_eq = (o_rec.id == i_ctl.new_rec.id);
    assign o_t_gt  = (o_rec.t > i_ctl.new_rec.t);

endmodule

[hw/rtl/ranked_gain_trial_table.sv]
// Top level of the ranked gain trial table: control sequencer and cell row.
// Depends on rgt_pkg and rgt_cell.
//
// Usage:
//   Input channel i_valid/i_ready carries one report beat (list, seconds held,
//   fresh gains). Output channel o_valid/o_ready carries one result beat per
//   report: the next gain set to try, whether it was reused, the record
//   outcome and the number of entries now kept in that list.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data; write only while idle.
//   Index 0 loads the keep threshold of both lists, 1..6 the start gains.
// Structure:
//   A row of TABLE_DEPTH cells holds the ranked entries of both lists. Each
//   cell compares its entry with the reported set and shifts entries to or
//   from its neighbors, so removal and ranked insertion shift all at once.
// Sequencing:
//   An accepted beat passes through search, optional removal, optional
//   insertion and threshold update, then selection of the next set, which
//   raises o_valid; the sequencer then returns to idle. One report is worked
//   on at a time; a new report is taken while the previous result still waits.
// Reset:
//   Lists empty, cursors and id counter zero, threshold 20, start gains zero.
//   Table contents are not cleared; entries past the list length are unused.
// Stall:
//   A result held by a stalled receiver stays in the output register; the
//   next report stops at its selection step until the output is free.
module ranked_gain_trial_table #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           i_ready,
    input  rgt_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           o_ready,
    output rgt_pkg::t_out  o_out,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_THR  = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;

    logic [2:0]          r_state;
    rgt_pkg::t_in        r_in;
    rgt_pkg::t_rec       r_cur;
    logic [LW-1:0]       r_len    [2];
    logic [15:0]         r_short  [2];
    logic [LW-1:0]       r_cursor [2];
    rgt_pkg::t_rec       r_set    [2];
    logic [15:0]         r_counter;
    logic                r_found;
    logic [IW-1:0]       r_hit;
    logic [1:0]          r_outcome;
    rgt_pkg::t_out       r_out;
    logic                r_ovalid;

    rgt_pkg::t_cell_ctl  ctl;
    rgt_pkg::t_rec       cell_rec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] id_eq;
    logic [TABLE_DEPTH-1:0] t_gt;

    logic                lst;
    logic [LW-1:0]       len_l;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic [LW-1:0]       ins_pos;
    logic [LW-1:0]       cur_l;
    rgt_pkg::t_rec       nrec;

    assign lst     = r_in.which_list;
    assign len_l   = r_len[lst];
    assign cur_l   = r_cursor[lst];
    assign i_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // Cell row: each cell hands its entry to both neighbors.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rgt_pkg::t_rec left_rec;
        rgt_pkg::t_rec right_rec;
        if (g == 0) begin : g_first
            assign left_rec = ctl.new_rec;
        end else begin : g_mid_l
            assign left_rec = cell_rec[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign right_rec = ctl.new_rec;
        end else begin : g_mid_r
            assign right_rec = cell_rec[g+1];
        end
        rgt_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_rec),
            .i_right (right_rec),
            .o_rec   (cell_rec[g]),
            .o_id_eq (id_eq[g]),
            .o_t_gt  (t_gt[g])
        );
    end

    // First matching id and first slot whose time does not beat the report.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        ins_pos = len_l;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (LW'(k) < len_l && id_eq[k]) begin
                hit     = 1'b1;
                hit_idx = IW'(k);
            end
            if (LW'(k) < len_l && !t_gt[k]) begin
                ins_pos = LW'(k);
            end
        end
    end

    // Drive the cell row for the removal and insertion steps.
    always_comb begin
        ctl.op      = rgt_pkg::OP_HOLD;
        ctl.list    = lst;
        ctl.pos     = rgt_pkg::POS_W'(ins_pos);
        ctl.lim     = rgt_pkg::POS_W'(len_l);
        ctl.new_rec = r_cur;
        if (r_state == S_REM) begin
            ctl.op  = rgt_pkg::OP_SHL;
            ctl.pos = rgt_pkg::POS_W'(r_hit);
        end else if (r_state == S_INS && ins_pos < DEPTH_L) begin
            ctl.op  = rgt_pkg::OP_INS;
        end
    end

    always_comb begin
        nrec = cell_rec[cur_l[IW-1:0]];
        nrec.t = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counter <= '0;
            r_ovalid  <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                r_len[l]    <= '0;
                r_cursor[l] <= '0;
                r_short[l]  <= rgt_pkg::RESET_MIN_HOLD;
                r_set[l]    <= '0;
            end
        end else begin
            // Drop the delivered beat; the selection step reloads it itself.
            if (r_ovalid && o_ready && r_state != S_NEXT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        unique case (i_cfg_idx)
                            rgt_pkg::CFG_MIN_HOLD: begin
                                r_short[0] <= i_cfg_data;
                                r_short[1] <= i_cfg_data;
                            end
                            rgt_pkg::CFG_POS_P: r_set[0].p <= i_cfg_data;
                            rgt_pkg::CFG_POS_I: r_set[0].i <= i_cfg_data;
                            rgt_pkg::CFG_POS_D: r_set[0].d <= i_cfg_data;
                            rgt_pkg::CFG_NEG_P: r_set[1].p <= i_cfg_data;
                            rgt_pkg::CFG_NEG_I: r_set[1].i <= i_cfg_data;
                            rgt_pkg::CFG_NEG_D: r_set[1].d <= i_cfg_data;
                            default: begin
                            end
                        endcase
                    end
                    if (i_valid) begin
                        r_in      <= i_in;
                        r_cur     <= '{id: r_set[i_in.which_list].id,
                                       p:  r_set[i_in.which_list].p,
                                       i:  r_set[i_in.which_list].i,
                                       d:  r_set[i_in.which_list].d,
                                       t:  i_in.held_seconds};
                        r_found   <= 1'b0;
                        r_outcome <= rgt_pkg::OUT_NONE;
                        r_state   <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_hit   <= hit_idx;
                        if (r_cur.t > cell_rec[hit_idx].t) begin
                            r_outcome <= rgt_pkg::OUT_IMPROVED;
                            r_state   <= S_REM;
                        end else begin
                            r_outcome <= rgt_pkg::OUT_KEPT;
                            r_state   <= S_NEXT;
                        end
                    end else if (r_cur.t > r_short[lst]) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_REM: begin
                    r_len[lst] <= len_l - 1'b1;
                    r_state    <= S_INS;
                end
                S_INS: begin
                    // Full table with every time longer: nothing is stored.
                    if (ins_pos < DEPTH_L) begin
                        r_outcome <= r_found ? rgt_pkg::OUT_IMPROVED : rgt_pkg::OUT_ADDED;
                        if (len_l < DEPTH_L) begin
                            r_len[lst] <= len_l + 1'b1;
                        end
                    end
                    r_state <= S_THR;
                end
                S_THR: begin
                    // A full table raises or lowers the threshold to its last time.
                    if (len_l >= DEPTH_L) begin
                        r_short[lst] <= cell_rec[TABLE_DEPTH-1].t;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!r_ovalid || o_ready) begin
                        if (cur_l < len_l) begin
                            r_set[lst]              <= nrec;
                            r_cursor[lst]           <= cur_l + 1'b1;
                            r_out.next_id           <= nrec.id;
                            r_out.next_p            <= nrec.p;
                            r_out.next_i            <= nrec.i;
                            r_out.next_d            <= nrec.d;
                            r_out.reused_from_table <= 1'b1;
                        end else begin
                            r_counter               <= r_counter + 1'b1;
                            r_set[lst].id           <= r_counter + 1'b1;
                            r_set[lst].p            <= 16'(r_in.fresh_p);
                            r_set[lst].i            <= 16'(r_in.fresh_i);
                            r_set[lst].d            <= 16'(r_in.fresh_d);
                            r_set[lst].t            <= '0;
                            r_cursor[lst]           <= '0;
                            r_out.next_id           <= r_counter + 1'b1;
                            r_out.next_p            <= 16'(r_in.fresh_p);
                            r_out.next_i            <= 16'(r_in.fresh_i);
                            r_out.next_d            <= 16'(r_in.fresh_d);
                            r_out.reused_from_table <= 1'b0;
                        end
                        r_out.record_outcome <= r_outcome;
                        r_out.stored_count   <= 4'(len_l);
                        r_ovalid             <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Lists never grow past the table.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[0] <= DEPTH_L && r_len[1] <= DEPTH_L)
        else $error("list length exceeds table depth");

    // Cursor never runs past the table.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor[0] <= DEPTH_L && r_cursor[1] <= DEPTH_L)
        else $error("reuse cursor past table depth");

    // An accepted report starts with the search step.
    a_accept_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> r_state == S_FIND)
        else $error("accepted report did not start search");

    // A finished result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_ready |=> r_ovalid && $stable(r_out))
        else $error("stalled result changed");

endmodule

[dv/tb.sv]
// Testbench for ranked_gain_trial_table: random and directed report beats,
// checked against a behavioral ranking model. Depends on rgt_pkg and the RTL.
module tb;

    localparam int DEPTH = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready;
    rgt_pkg::t_in   i_in = '0;
    logic  o_valid;
    logic  o_ready = 1'b0;
    rgt_pkg::t_out  o_out;
    logic  i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = rgt_pkg::CFG_MIN_HOLD;
    logic [15:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    ranked_gain_trial_table #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

    // Model state of both lists.
    rgt_pkg::t_rec rank_tbl [2][DEPTH];
    int            rank_len [2];
    logic [15:0]   keep_floor [2];
    int            cursor [2];
    rgt_pkg::t_rec trial_set [2];
    logic [15:0]   id_counter;

    rgt_pkg::t_out pending_results [$];
    int   fail_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_off = 0;
    int   quiet_cycles = 0;

    function automatic void model_reset();
        for (int l = 0; l < 2; l++) begin
            rank_len[l] = 0;
            keep_floor[l] = rgt_pkg::RESET_MIN_HOLD;
            cursor[l] = 0;
            trial_set[l] = '0;
        end
        id_counter = '0;
    endfunction

    function automatic void model_cfg(logic [2:0] idx, logic [15:0] v);
        int l;
        if (idx == rgt_pkg::CFG_MIN_HOLD) begin
            keep_floor[0] = v;
            keep_floor[1] = v;
        end else if (idx <= rgt_pkg::CFG_NEG_D) begin
            l = (idx >= rgt_pkg::CFG_NEG_P) ? 1 : 0;
            case (idx)
                rgt_pkg::CFG_POS_P, rgt_pkg::CFG_NEG_P: trial_set[l].p = v;
                rgt_pkg::CFG_POS_I, rgt_pkg::CFG_NEG_I: trial_set[l].i = v;
                default:                                trial_set[l].d = v;
            endcase
        end
    endfunction

    // Insert in rank order; equal times go ahead of existing entries.
    // Returns 1 when the entry was stored.
    function automatic bit ranked_insert(int l, rgt_pkg::t_rec r);
        int n;
        int pos;
        bit stored;
        n = rank_len[l];
        pos = 0;
        stored = 1'b0;
        while (pos < n && rank_tbl[l][pos].t > r.t) pos++;
        if (pos < DEPTH) begin
            for (int k = n; k > pos; k--)
                if (k < DEPTH) rank_tbl[l][k] = rank_tbl[l][k-1];
            rank_tbl[l][pos] = r;
            if (n < DEPTH) rank_len[l] = n + 1;
            stored = 1'b1;
        end
        if (rank_len[l] >= DEPTH) keep_floor[l] = rank_tbl[l][rank_len[l]-1].t;
        return stored;
    endfunction

    function automatic rgt_pkg::t_out next_trial(rgt_pkg::t_in b);
        int   l;
        rgt_pkg::t_rec cur;
        rgt_pkg::t_out r;
        logic found;
        bit   stored;
        l = b.which_list;
        cur = trial_set[l];
        cur.t = b.held_seconds;
        r = '0;
        r.record_outcome = rgt_pkg::OUT_NONE;
        found = 1'b0;
        for (int k = 0; k < rank_len[l]; k++) begin
            if (!found && rank_tbl[l][k].id == cur.id) begin
                found = 1'b1;
                if (b.held_seconds > rank_tbl[l][k].t) begin
                    for (int j = k; j + 1 < rank_len[l]; j++)
                        rank_tbl[l][j] = rank_tbl[l][j+1];
                    rank_len[l]--;
                    stored = ranked_insert(l, cur);
                    r.record_outcome = rgt_pkg::OUT_IMPROVED;
                end else begin
                    r.record_outcome = rgt_pkg::OUT_KEPT;
                end
            end
        end
        if (!found && b.held_seconds > keep_floor[l]) begin
            if (ranked_insert(l, cur)) r.record_outcome = rgt_pkg::OUT_ADDED;
        end
        if (cursor[l] < rank_len[l]) begin
            cur = rank_tbl[l][cursor[l]];
            cursor[l]++;
            r.reused_from_table = 1'b1;
        end else begin
            id_counter++;
            cur.id = id_counter;
            cur.p = 16'(b.fresh_p);
            cur.i = 16'(b.fresh_i);
            cur.d = 16'(b.fresh_d);
            cursor[l] = 0;
        end
        cur.t = '0;
        trial_set[l] = cur;
        r.next_id = cur.id;
        r.next_p = cur.p;
        r.next_i = cur.i;
        r.next_d = cur.d;
        r.stored_count = 4'(rank_len[l]);
        return r;
    endfunction

    // Receiver: random stall, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            o_ready <= 1'b0;
        end else begin
            o_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result beat against the oldest expectation.
    always @(posedge i_clk) begin
        rgt_pkg::t_out e;
        if (i_rst_n && o_valid && o_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out);
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (o_out.next_id !== e.next_id) begin
                    $error("next_id exp %0d got %0d", e.next_id, o_out.next_id);
                    fail_cnt++;
                end
                if (o_out.next_p !== e.next_p) begin
                    $error("next_p exp %0d got %0d", e.next_p, o_out.next_p);
                    fail_cnt++;
                end
                if (o_out.next_i !== e.next_i) begin
                    $error("next_i exp %0d got %0d", e.next_i, o_out.next_i);
                    fail_cnt++;
                end
                if (o_out.next_d !== e.next_d) begin
                    $error("next_d exp %0d got %0d", e.next_d, o_out.next_d);
                    fail_cnt++;
                end
                if (o_out.reused_from_table !== e.reused_from_table) begin
                    $error("reused_from_table exp %0d got %0d",
                           e.reused_from_table, o_out.reused_from_table);
                    fail_cnt++;
                end
                if (o_out.record_outcome !== e.record_outcome) begin
                    $error("record_outcome exp %0d got %0d",
                           e.record_outcome, o_out.record_outcome);
                    fail_cnt++;
                end
                if (o_out.stored_count !== e.stored_count) begin
                    $error("stored_count exp %0d got %0d",
                           e.stored_count, o_out.stored_count);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && i_ready) || (o_valid && o_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ranked_gain_trial_table: mismatch");
            $finish;
        end
    end

    // Send one report beat; hold valid until accepted, predict at acceptance.
    // Valid stays high on return so the next beat can follow with no gap.
    task automatic send_report(rgt_pkg::t_in b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!i_ready);
        pending_results.push_back(next_trial(b));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_cfg(idx, v);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every result, then a margin for the block to settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Mostly reports that repeat a short set of times so sets are re-tried.
    function automatic rgt_pkg::t_in rand_report(int span);
        rgt_pkg::t_in b;
        b.which_list = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       b.held_seconds = 16'($urandom);
            1:       b.held_seconds = 16'hFFFF;
            default: b.held_seconds = 16'($urandom_range(span));
        endcase
        b.fresh_p = 10'($urandom_range(599));
        b.fresh_i = 10'($urandom_range(599));
        b.fresh_d = 14'($urandom_range(11999));
        if ($urandom_range(19) == 0) begin
            b.fresh_p = 10'($urandom);
            b.fresh_i = 10'($urandom);
            b.fresh_d = 14'($urandom);
        end
        return b;
    endfunction

    // Directed rows: report beat, whether a result is typed in, typed result.
    typedef struct {
        rgt_pkg::t_in  b;
        logic          typed;
        rgt_pkg::t_out want;
    } t_row;

    t_row dir_rows [$];

    initial begin
        t_row r;
        rgt_pkg::t_out got;
        model_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First report after reset: short time, not recorded,
        // fresh gains under id 1.
        r.b = '{which_list: 1'b0, held_seconds: 16'd20, fresh_p: 10'd599,
                fresh_i: 10'd0, fresh_d: 14'd11999};
        r.typed = 1'b1;
        r.want = '{next_id: 16'd1, next_p: 16'd599, next_i: 16'd0,
                   next_d: 16'd11999, reused_from_table: 1'b0,
                   record_outcome: rgt_pkg::OUT_NONE, stored_count: 4'd0};
        dir_rows.push_back(r);
        r.typed = 1'b0;
        // Added, kept, improved, ties, full table and drop-out, both lists.
        for (int k = 0; k < 22; k++) begin
            r.b.which_list = 1'(k >= 14);
            r.b.held_seconds = (k % 5 == 0) ? 16'hFFFF : 16'(21 + (k % 4) * 10);
            r.b.fresh_p = 10'(k * 37);
            r.b.fresh_i = 10'(599 - k);
            r.b.fresh_d = (k % 2) ? 14'h3FFF : 14'd0;
            dir_rows.push_back(r);
        end
        foreach (dir_rows[n]) begin
            send_report(dir_rows[n].b);
            if (dir_rows[n].typed) begin
                got = pending_results[$];
                if (got !== dir_rows[n].want) begin
                    $error("directed row %0d exp %p model %p", n,
                           dir_rows[n].want, got);
                    fail_cnt++;
                end
            end
        end
        drain();

        // Settings: reset values first, then extremes and random.
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) begin
                write_reg(rgt_pkg::CFG_MIN_HOLD, 16'd0);
                for (logic [2:0] x = rgt_pkg::CFG_POS_P; x <= rgt_pkg::CFG_NEG_D; x++)
                    write_reg(x, 16'hFFFF);
            end else if (phase == 2) begin
                write_reg(rgt_pkg::CFG_MIN_HOLD, 16'hFFFF);
                for (logic [2:0] x = rgt_pkg::CFG_POS_P; x <= rgt_pkg::CFG_NEG_D; x++)
                    write_reg(x, 16'h0000);
            end else if (phase == 3) begin
                write_reg(rgt_pkg::CFG_MIN_HOLD, 16'($urandom_range(200)));
                for (logic [2:0] x = rgt_pkg::CFG_POS_P; x <= rgt_pkg::CFG_NEG_D; x++)
                    write_reg(x, 16'($urandom));
            end
            for (int seg = 0; seg < 3; seg++) begin
                send_idle_pct = (seg == 0) ? 7 : (seg == 1) ? 71 : 0;
                recv_idle_pct = (seg == 0) ? 71 : (seg == 1) ? 7 : 0;
                if (phase == 0 && seg == 2) hold_off = 300;
                for (int n = 0; n < 140; n++)
                    send_report(rand_report(phase == 2 ? 16'hFFFF : 400));
            end
            drain();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (fail_cnt == 0) begin
            $display("ranked_gain_trial_table: match");
        end else begin
            $display("ranked_gain_trial_table: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rgt_pkg.sv
hw/rtl/rgt_cell.sv
hw/rtl/ranked_gain_trial_table.sv
dv/tb.sv
